>>> hw/rtl/jsu_pkg.sv
`timescale 1ns / 1ps
// Package for the JSON string unescaper: item types, codes and decode helpers.
// No dependencies; every module of the block imports it.
package jsu_pkg;

  localparam int unsigned JsuQueueDepth = 4;

  typedef enum logic [1:0] {
    SCAN_IDLE = 2'd0,
    SCAN_TEXT = 2'd1,
    SCAN_ESC  = 2'd2,
    SCAN_HEX  = 2'd3
  } scan_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  localparam logic [7:0] ChrDquote = 8'h22;
  localparam logic [7:0] ChrSquote = 8'h27;
  localparam logic [7:0] ChrBslash = 8'h5c;
  localparam logic [7:0] ChrSlash  = 8'h2f;
  localparam logic [7:0] ChrU      = 8'h75;
  localparam logic [7:0] ChrNul    = 8'h00;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_token;
  } jsu_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last_of_run;
  } jsu_out_t;

  // Work for the back end: up to three result bytes from one input item.
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } jsu_job_t;

  // Returns {valid, value}.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // Returns {valid, byte} for the single-byte escape letters.
  function automatic logic [8:0] escape_byte(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      ChrDquote: r = {1'b1, ChrDquote};
      ChrSquote: r = {1'b1, ChrSquote};
      ChrBslash: r = {1'b1, ChrBslash};
      ChrSlash:  r = {1'b1, ChrSlash};
      8'h62:     r = {1'b1, 8'h08};
      8'h66:     r = {1'b1, 8'h0c};
      8'h6e:     r = {1'b1, 8'h0a};
      8'h72:     r = {1'b1, 8'h0d};
      8'h74:     r = {1'b1, 8'h09};
      default:   r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/jsu_front.sv
`timescale 1ns / 1ps
// Front end of the JSON string unescaper: scan state and per-byte classification.
// Depends on jsu_pkg; produces at most one job per accepted byte for the job queue.
module jsu_front import jsu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  jsu_in_t  item_i,
  output logic     job_valid_o,
  output jsu_job_t job_o
);

  scan_e       mode_q, mode_d;
  logic        sq_q, sq_d;
  logic [1:0]  hex_q, hex_d;
  logic [15:0] cp_q, cp_d;

  logic [7:0]  c;
  logic [7:0]  quote;
  logic [4:0]  hv;
  logic [8:0]  ev;
  logic [15:0] cp_new;
  jsu_job_t    job;

  assign c      = item_i.in_byte;
  assign quote  = sq_q ? ChrSquote : ChrDquote;
  assign hv     = hex_value(c);
  assign ev     = escape_byte(c);
  assign cp_new = {cp_q[11:0], hv[3:0]};

  always_comb begin
    mode_d = mode_q;
    sq_d   = sq_q;
    hex_d  = hex_q;
    cp_d   = cp_q;
    job    = '0;
    if (item_i.start_of_token) begin
      sq_d   = (c != ChrDquote);
      mode_d = SCAN_TEXT;
      hex_d  = 2'd0;
      cp_d   = 16'd0;
    end else begin
      case (mode_q)
        SCAN_TEXT: begin
          if (c == ChrNul || c == quote) begin
            job.kind = KIND_END;
            job.cnt  = 2'd1;
            mode_d   = SCAN_IDLE;
          end else if (c == ChrBslash) begin
            mode_d = SCAN_ESC;
          end else begin
            job.kind = KIND_DATA;
            job.cnt  = 2'd1;
            job.b0   = c;
          end
        end
        SCAN_ESC: begin
          if (c == ChrU) begin
            mode_d = SCAN_HEX;
            hex_d  = 2'd0;
            cp_d   = 16'd0;
          end else if (!ev[8]) begin
            job.kind = KIND_ERR;
            job.cnt  = 2'd1;
            mode_d   = SCAN_IDLE;
          end else begin
            job.kind = KIND_DATA;
            job.cnt  = 2'd1;
            job.b0   = ev[7:0];
            mode_d   = SCAN_TEXT;
          end
        end
        SCAN_HEX: begin
          if (!hv[4]) begin
            job.kind = KIND_ERR;
            job.cnt  = 2'd1;
            mode_d   = SCAN_IDLE;
            hex_d    = 2'd0;
          end else begin
            cp_d = cp_new;
            if (hex_q == 2'd3) begin
              hex_d    = 2'd0;
              mode_d   = SCAN_TEXT;
              job.kind = KIND_DATA;
              // UTF-8 encoding of the gathered code point; a zero code point emits nothing.
              if (cp_new == 16'd0) begin
                job.cnt = 2'd0;
              end else if (cp_new <= 16'h007f) begin
                job.cnt = 2'd1;
                job.b0  = {1'b0, cp_new[6:0]};
              end else if (cp_new <= 16'h07ff) begin
                job.cnt = 2'd2;
                job.b0  = 8'hc0 | {3'b000, cp_new[10:6]};
                job.b1  = 8'h80 | {2'b00, cp_new[5:0]};
              end else begin
                job.cnt = 2'd3;
                job.b0  = 8'he0 | {4'b0000, cp_new[15:12]};
                job.b1  = 8'h80 | {2'b00, cp_new[11:6]};
                job.b2  = 8'h80 | {2'b00, cp_new[5:0]};
              end
            end else begin
              hex_d = hex_q + 2'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= SCAN_IDLE;
      sq_q   <= 1'b0;
      hex_q  <= 2'd0;
      cp_q   <= 16'd0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      sq_q   <= sq_d;
      hex_q  <= hex_d;
      cp_q   <= cp_d;
    end
  end

  assign job_valid_o = accept_i && (job.cnt != 2'd0);
  assign job_o       = job;

endmodule

>>> hw/rtl/jsu_queue.sv
`timescale 1ns / 1ps
// Job queue between the front and back ends of the JSON string unescaper.
// Depends on jsu_pkg for the job type.
module jsu_queue import jsu_pkg::*; #(
  parameter int unsigned Depth = JsuQueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_i,
  input  jsu_job_t wr_data_i,
  output logic     full_o,
  input  logic     rd_i,
  output logic     empty_o,
  output jsu_job_t rd_data_o
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned Cw = $clog2(Depth + 1);

  jsu_job_t       slots_q [Depth];
  logic [Aw-1:0]  wr_ptr_q, wr_ptr_d;
  logic [Aw-1:0]  rd_ptr_q, rd_ptr_d;
  logic [Cw-1:0]  count_q, count_d;
  logic           do_wr, do_rd;

  assign full_o    = (count_q == Cw'(Depth));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == Aw'(Depth - 1)) ? '0 : wr_ptr_q + Aw'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == Aw'(Depth - 1)) ? '0 : rd_ptr_q + Aw'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + Cw'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - Cw'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slots_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

>>> hw/rtl/jsu_back.sv
`timescale 1ns / 1ps
// Back end of the JSON string unescaper: holds one job and hands out its bytes.
// Depends on jsu_pkg; fed from jsu_queue.
module jsu_back import jsu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_empty_i,
  input  jsu_job_t q_data_i,
  output logic     q_rd_o,
  output logic     empty,
  input  logic     pop,
  output jsu_out_t out_item_o
);

  jsu_job_t   job_q;
  logic [1:0] idx_q;
  logic       busy_q;
  logic       last;
  logic       take;
  logic       load;
  logic [7:0] sel_byte;

  assign last  = (idx_q == job_q.cnt - 2'd1);
  assign take  = pop && busy_q;
  // A new job loads when the register is free or its final byte leaves now.
  assign load  = !q_empty_i && (!busy_q || (take && last));
  assign q_rd_o = load;
  assign empty = !busy_q;

  always_comb begin
    case (idx_q)
      2'd1:    sel_byte = job_q.b1;
      2'd2:    sel_byte = job_q.b2;
      default: sel_byte = job_q.b0;
    endcase
  end

  assign out_item_o.kind        = job_q.kind;
  assign out_item_o.out_byte    = sel_byte;
  assign out_item_o.last_of_run = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (load) begin
      busy_q <= 1'b1;
      idx_q  <= 2'd0;
    end else if (take && last) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (take) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= q_data_i;
    end
  end

  a_busy_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (job_q.cnt != 2'd0 && idx_q < job_q.cnt))
    else $error("result register holds a job with no bytes left");

  a_status_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && job_q.kind != KIND_DATA) |-> (job_q.cnt == 2'd1 && job_q.b0 == 8'd0))
    else $error("end or error result is not a single zero result");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !pop) |=> (busy_q && $stable(idx_q)))
    else $error("waiting result changed while stalled");

endmodule

>>> hw/rtl/json_string_unescape_core.sv
`timescale 1ns / 1ps
// A result passes through the job queue and the back end's result register before it shows.
// Throughput: one input byte per cycle unless full, one result per cycle while pop is high;
// a \u escape's 1 to 3 bytes leave the back end one per cycle and the queue absorbs the gap.
// Reset (async, active low) puts the scanner idle and empties the queue and output register.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
module json_string_unescape_core import jsu_pkg::*; #(
  parameter int unsigned QueueDepth = JsuQueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  jsu_in_t  in_item_i,
  output logic     empty,
  input  logic     pop,
  output jsu_out_t out_item_o
);

  logic     accept;
  logic     job_valid;
  jsu_job_t job;
  logic     q_full;
  logic     q_empty;
  logic     q_rd;
  jsu_job_t q_data;

  assign full   = q_full;
  assign accept = push && !q_full;

  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .job_valid_o(job_valid),
    .job_o      (job)
  );

  jsu_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (job_valid),
    .wr_data_i(job),
    .full_o   (q_full),
    .rd_i     (q_rd),
    .empty_o  (q_empty),
    .rd_data_o(q_data)
  );

  jsu_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_rd_o    (q_rd),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item_o)
  );

endmodule
